// File: rtl/core/ultrasonic_echo_ranger_assert.svh
// Assertion macros for the ultrasonic echo ranger port checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uer: next-cycle check failed");

`endif

// File: rtl/core/uer_pkg.sv
// Package for the ultrasonic echo ranger: configuration and result types,
// register indexes, reset values and timing constants. No dependencies.
package uer_pkg;

    // Microsecond ticks in one millisecond.
    localparam int unsigned TICKS_PER_MS = 1000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TRIGGER_TICKS   = 2'd0;
    localparam logic [1:0] CFG_RISE_TIMEOUT_MS = 2'd1;
    localparam logic [1:0] CFG_FALL_TIMEOUT_MS = 2'd2;
    localparam logic [1:0] CFG_DISTANCE_SHIFT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [9:0] RST_TRIGGER_TICKS   = 10'd10;
    localparam logic [5:0] RST_RISE_TIMEOUT_MS = 6'd1;
    localparam logic [5:0] RST_FALL_TIMEOUT_MS = 6'd30;
    localparam logic [3:0] RST_DISTANCE_SHIFT  = 4'd6;

    typedef struct packed {
        logic [9:0] trigger_ticks;
        logic [5:0] rise_timeout_ms;
        logic [5:0] fall_timeout_ms;
        logic [3:0] distance_shift;
    } cfg_t;

    typedef struct packed {
        logic        trigger;
        logic        done_res;
        logic        timed_out;
        logic [15:0] distance;
        logic        busy_res;
    } res_t;

endpackage

// File: rtl/core/uer_in_if.sv
// Input channel of the ultrasonic echo ranger: one tick per transfer.
// Standalone; no package needed.
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink (input valid, input start_req, input echo, output ready);
endinterface

// File: rtl/core/uer_out_if.sv
// Result channel of the ultrasonic echo ranger: one result per transfer.
// Standalone; no package needed.
interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger;
    logic        done_res;
    logic        timed_out;
    logic [15:0] distance;
    logic        busy_res;

    modport source (output valid, output trigger, output done_res, output timed_out,
                    output distance, output busy_res, input ready);
    modport sink (input valid, input trigger, input done_res, input timed_out,
                  input distance, input busy_res, output ready);
endinterface

// File: rtl/core/uer_cfg_regs.sv
// Configuration register bank of the ultrasonic echo ranger.
// Depends on uer_pkg for the register type, indexes and reset values.
module uer_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_wdata,
    output uer_pkg::cfg_t     cfg
);
    import uer_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; each register takes the low bits of the write data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIGGER_TICKS:   cfg_next.trigger_ticks   = cfg_wdata;
                CFG_RISE_TIMEOUT_MS: cfg_next.rise_timeout_ms = cfg_wdata[5:0];
                CFG_FALL_TIMEOUT_MS: cfg_next.fall_timeout_ms = cfg_wdata[5:0];
                CFG_DISTANCE_SHIFT:  cfg_next.distance_shift  = cfg_wdata[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks   <= RST_TRIGGER_TICKS;
            cfg_reg.rise_timeout_ms <= RST_RISE_TIMEOUT_MS;
            cfg_reg.fall_timeout_ms <= RST_FALL_TIMEOUT_MS;
            cfg_reg.distance_shift  <= RST_DISTANCE_SHIFT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/uer_engine.sv
// Measurement sequencer of the ultrasonic echo ranger: phase, trigger count
// and elapsed time, advanced by one tick per step. Depends on uer_pkg.
module uer_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              start_req,
    input  logic              echo,
    input  uer_pkg::cfg_t     cfg,
    output uer_pkg::res_t     res
);
    import uer_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_FALL = 2'd3;

    localparam logic [9:0] US_WRAP = 10'(TICKS_PER_MS);

    logic [1:0] phase_reg, phase_next;
    logic [9:0] trig_cnt_reg, trig_cnt_next;
    logic [5:0] ms_reg, ms_next;
    logic [9:0] us_reg, us_next;

    logic [9:0]  us_inc;
    logic [9:0]  us_adv;
    logic [5:0]  ms_adv;
    logic [9:0]  trig_cnt_inc;
    logic [15:0] scaled_time;

    // Elapsed time one tick on; microseconds wrap into milliseconds.
    always_comb
    begin
        us_inc = us_reg + 10'd1;
        if (us_inc >= US_WRAP)
        begin
            us_adv = '0;
            ms_adv = ms_reg + 6'd1;
        end
        else
        begin
            us_adv = us_inc;
            ms_adv = ms_reg;
        end
    end

    assign trig_cnt_inc = trig_cnt_reg + 10'd1;
    // Microseconds stay below 1024, so milliseconds times 1024 is a concatenation.
    assign scaled_time  = {ms_adv, us_adv};

    // Next phase and this tick's result.
    always_comb
    begin
        phase_next    = phase_reg;
        trig_cnt_next = trig_cnt_reg;
        ms_next       = ms_reg;
        us_next       = us_reg;
        res           = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    res.trigger   = 1'b1;
                    trig_cnt_next = 10'd1;
                    if (10'd1 >= cfg.trigger_ticks)
                    begin
                        phase_next = PH_RISE;
                        ms_next    = '0;
                        us_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                    end
                end
            end
            PH_TRIG:
            begin
                res.trigger   = 1'b1;
                trig_cnt_next = trig_cnt_inc;
                if (trig_cnt_inc >= cfg.trigger_ticks || trig_cnt_inc == 10'd0)
                begin
                    phase_next = PH_RISE;
                    ms_next    = '0;
                    us_next    = '0;
                end
            end
            PH_RISE:
            begin
                if (echo)
                begin
                    phase_next = PH_FALL;
                    ms_next    = '0;
                    us_next    = '0;
                end
                else
                begin
                    ms_next = ms_adv;
                    us_next = us_adv;
                    if (ms_adv >= cfg.rise_timeout_ms)
                    begin
                        res.done_res  = 1'b1;
                        res.timed_out = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
            end
            PH_FALL:
            begin
                ms_next = ms_adv;
                us_next = us_adv;
                // A falling echo wins over a timeout reached on the same tick.
                if (!echo)
                begin
                    res.done_res = 1'b1;
                    res.distance = scaled_time >> cfg.distance_shift;
                    phase_next   = PH_IDLE;
                end
                else if (ms_adv >= cfg.fall_timeout_ms)
                begin
                    res.done_res  = 1'b1;
                    res.timed_out = 1'b1;
                    phase_next    = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            trig_cnt_reg <= '0;
            ms_reg       <= '0;
            us_reg       <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            trig_cnt_reg <= trig_cnt_next;
            ms_reg       <= ms_next;
            us_reg       <= us_next;
        end
    end

endmodule

// File: rtl/core/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger. Each input transfer is one microsecond tick carrying a
// start request and the sampled echo level; each tick yields exactly one result
// transfer with the trigger level, completion, timeout and distance. Ticks are
// taken one per clock cycle, back to back, while the result side is not stalled;
// a tick passes an input register and the sequencer logic into a result register,
// from which its result is offered until it is taken. Configuration writes take
// effect on the next clock edge and are meant to be made while no measurement is
// running.
module ultrasonic_echo_ranger (
    input  logic        clk,
    input  logic        rst_n,
    uer_in_if.sink      in_ch,
    uer_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);
    import uer_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;

    logic in_valid_reg, in_valid_next;
    logic in_start_reg;
    logic in_echo_reg;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic step_en;
    logic in_xfer;

    uer_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uer_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .start_req (in_start_reg),
        .echo      (in_echo_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Flow control: a tick steps when the result register is free or drained.
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign step_en      = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || step_en;
    assign in_xfer      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_start_reg <= in_ch.start_req;
            in_echo_reg  <= in_ch.echo;
        end
        if (step_en)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.trigger   = res_reg.trigger;
    assign out_ch.done_res  = res_reg.done_res;
    assign out_ch.timed_out = res_reg.timed_out;
    assign out_ch.distance  = res_reg.distance;
    assign out_ch.busy_res  = res_reg.busy_res;

endmodule

// File: rtl/core/uer_checker.sv
// Port-level checks on the ultrasonic echo ranger results, bound to the top level.
// Depends on ultrasonic_echo_ranger_assert.svh for the assertion macros.
`include "ultrasonic_echo_ranger_assert.svh"

module uer_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        trigger,
    input logic        done_res,
    input logic        timed_out,
    input logic [15:0] distance,
    input logic        busy_res
);

    logic [19:0] out_payload;

    // The whole result payload, so that a stall can be checked in one comparison.
    assign out_payload = {trigger, done_res, timed_out, distance, busy_res};

    // A stalled result stays offered and unchanged.
    `UER_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

    // A timeout is only reported on a finished measurement.
    `UER_ASSERT_IMP(a_tout_done, out_valid && timed_out, done_res)

    // Distance is zero unless a measurement finished without timing out.
    `UER_ASSERT_IMP(a_dist_zero, out_valid && (timed_out || !done_res), distance == 16'd0)

    // A finished measurement leaves the block idle with the trigger low.
    `UER_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res && !trigger)

    // The trigger is only driven during a measurement.
    `UER_ASSERT_IMP(a_trig_busy, out_valid && trigger, busy_res)

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .trigger   (out_ch.trigger),
    .done_res  (out_ch.done_res),
    .timed_out (out_ch.timed_out),
    .distance  (out_ch.distance),
    .busy_res  (out_ch.busy_res)
);

// File: tb/sv/uer_range_checker.sv
// Checker for the ultrasonic echo ranger: watches both channels and the register port,
// predicts one reading per tick transfer and compares it with the result transfers.
// Depends on uer_pkg, uer_in_if and uer_out_if.
module uer_range_checker (
    input  logic       clk,
    input  logic       rst_n,
    uer_in_if          in_ch,
    uer_out_if         out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_wdata,
    output int         fail_count,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    typedef enum logic [1:0] {
        RANGER_IDLE,
        RANGER_TRIG,
        RANGER_RISE,
        RANGER_FALL
    } ranger_phase_e;

    cfg_t          regs;
    ranger_phase_e phase;
    logic [9:0]    trig_count;
    logic [5:0]    ms_count;
    logic [9:0]    us_count;
    res_t          pending_readings[$];

    // Prints one line per failure and counts it.
    task report_failure(input string msg);
        fail_count++;
        $display("%0t: uer mismatch: %s", $time, msg);
    endtask

    task check_field(input string name, input logic [15:0] got_v, input logic [15:0] want_v);
        if (got_v !== want_v)
        begin
            report_failure($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
        end
    endtask

    // One microsecond of echo time; the tick count wraps into milliseconds.
    task count_microsecond();
        us_count = us_count + 10'd1;
        if (us_count >= TICKS_PER_MS)
        begin
            us_count = '0;
            ms_count = ms_count + 6'd1;
        end
    endtask

    // Advances the sequencer by one tick and gives the reading it produces.
    task range_tick(input logic start, input logic echo_lvl, output res_t r);
        logic [31:0] scaled;
        r = '0;
        case (phase)
            RANGER_IDLE:
            begin
                if (start)
                begin
                    r.trigger  = 1'b1;
                    trig_count = 10'd1;
                    if (trig_count >= regs.trigger_ticks)
                    begin
                        phase    = RANGER_RISE;
                        ms_count = '0;
                        us_count = '0;
                    end
                    else
                    begin
                        phase = RANGER_TRIG;
                    end
                end
            end
            RANGER_TRIG:
            begin
                r.trigger  = 1'b1;
                trig_count = trig_count + 10'd1;
                if (trig_count >= regs.trigger_ticks || trig_count == '0)
                begin
                    phase    = RANGER_RISE;
                    ms_count = '0;
                    us_count = '0;
                end
            end
            RANGER_RISE:
            begin
                if (echo_lvl)
                begin
                    phase    = RANGER_FALL;
                    ms_count = '0;
                    us_count = '0;
                end
                else
                begin
                    count_microsecond();
                    if (ms_count >= regs.rise_timeout_ms)
                    begin
                        r.done_res  = 1'b1;
                        r.timed_out = 1'b1;
                        phase       = RANGER_IDLE;
                    end
                end
            end
            default:
            begin
                count_microsecond();
                if (!echo_lvl)
                begin
                    // The echo level wins over a timeout on the same tick.
                    scaled     = ({26'd0, ms_count} << 10) + {22'd0, us_count};
                    scaled     = scaled >> regs.distance_shift;
                    r.done_res = 1'b1;
                    r.distance = scaled[15:0];
                    phase      = RANGER_IDLE;
                end
                else if (ms_count >= regs.fall_timeout_ms)
                begin
                    r.done_res  = 1'b1;
                    r.timed_out = 1'b1;
                    phase       = RANGER_IDLE;
                end
            end
        endcase
        r.busy_res = (phase != RANGER_IDLE);
    endtask

    // Register writes, tick transfers and result transfers, all seen at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t reading;
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            regs.trigger_ticks   = RST_TRIGGER_TICKS;
            regs.rise_timeout_ms = RST_RISE_TIMEOUT_MS;
            regs.fall_timeout_ms = RST_FALL_TIMEOUT_MS;
            regs.distance_shift  = RST_DISTANCE_SHIFT;
            phase       = RANGER_IDLE;
            trig_count  = '0;
            ms_count    = '0;
            us_count    = '0;
            fail_count  = 0;
            pending_readings.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRIGGER_TICKS:   regs.trigger_ticks   = cfg_wdata;
                    CFG_RISE_TIMEOUT_MS: regs.rise_timeout_ms = cfg_wdata[5:0];
                    CFG_FALL_TIMEOUT_MS: regs.fall_timeout_ms = cfg_wdata[5:0];
                    default:             regs.distance_shift  = cfg_wdata[3:0];
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                range_tick(in_ch.start_req, in_ch.echo, reading);
                pending_readings.push_back(reading);
            end

            if (out_ch.valid && out_ch.ready)
            begin
                got.trigger   = out_ch.trigger;
                got.done_res  = out_ch.done_res;
                got.timed_out = out_ch.timed_out;
                got.distance  = out_ch.distance;
                got.busy_res  = out_ch.busy_res;
                if (pending_readings.size() == 0)
                begin
                    report_failure("result transfer with no reading expected");
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("trigger", got.trigger, want.trigger);
                    check_field("done_res", got.done_res, want.done_res);
                    check_field("timed_out", got.timed_out, want.timed_out);
                    check_field("distance", got.distance, want.distance);
                    check_field("busy_res", got.busy_res, want.busy_res);
                end
            end
            outstanding = pending_readings.size();
        end
    end

endmodule

// File: tb/sv/tb_ultrasonic_echo_ranger.sv
// Top of the ultrasonic echo ranger testbench: clock, reset, tick stimulus, result
// back-pressure and the verdict. Depends on uer_pkg, both channel interfaces, the
// block itself and uer_range_checker.
module tb_ultrasonic_echo_ranger;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int RANDOM_TICKS    = 950;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_CYCLES = 120;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [9:0] cfg_wdata;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int tick_count = 0;
    int hold_requests = 0;
    bit idle_on = 1'b1;

    // Register values as last written, used only to shape the tick sequences.
    logic [9:0] cur_trig;
    logic [5:0] cur_rise;
    logic [5:0] cur_fall;

    uer_in_if  in_bus ();
    uer_out_if out_bus ();

    ultrasonic_echo_ranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_bus),
        .out_ch    (out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    uer_range_checker range_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_bus),
        .out_ch      (out_bus),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: short random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : result_sink
        int stall;
        int holds_seen;
        stall = 0;
        holds_seen = 0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                stall = HOLD_OFF_CYCLES;
            end
            else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 4);
            end
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Offers one tick, sometimes after an idle burst, and returns at its transfer.
    task send_tick(input logic start, input logic echo_lvl);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.start_req <= start;
        in_bus.echo      <= echo_lvl;
        do
            @(posedge clk);
        while (!in_bus.ready);
        tick_count++;
    endtask

    // Stops offering ticks until every reading has come back, then lets the block settle.
    task wait_for_results();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers while the block is idle; upper data bits are kept as given.
    task configure(input logic [9:0] trig_w, input logic [9:0] rise_w,
                   input logic [9:0] fall_w, input logic [9:0] shift_w);
        logic [1:0] idx [4];
        logic [9:0] vals [4];
        wait_for_results();
        idx  = '{CFG_TRIGGER_TICKS, CFG_RISE_TIMEOUT_MS, CFG_FALL_TIMEOUT_MS, CFG_DISTANCE_SHIFT};
        vals = '{trig_w, rise_w, fall_w, shift_w};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        cur_trig = trig_w;
        cur_rise = rise_w[5:0];
        cur_fall = fall_w[5:0];
    endtask

    // One measurement: start, the trigger ticks, a low wait, an echo pulse and,
    // when asked, the falling tick. The block ignores start requests inside while it is busy.
    task run_measure(input int rise_wait, input int high_len, input bit finish);
        int trig_len;
        trig_len = (cur_trig == '0) ? 1 : int'(cur_trig);
        send_tick(1'b1, 1'($urandom));
        repeat (trig_len - 1) send_tick(1'($urandom), 1'($urandom));
        repeat (rise_wait) send_tick(1'($urandom), 1'b0);
        repeat (high_len) send_tick(1'($urandom), 1'b1);
        if (finish)
        begin
            send_tick(1'($urandom), 1'b0);
        end
    endtask

    // Idle ticks with a noisy echo and no start request.
    task idle_noise(input int n);
        repeat (n) send_tick(1'b0, 1'($urandom));
    endtask

    // Mostly complete measurements kept inside the timeouts, some broken ones
    // where a zero timeout makes them cheap, and idle noise between them.
    task random_measure();
        int rise_lim;
        int high_lim;
        int rise_wait;
        int high_len;
        rise_lim  = (cur_rise == '0) ? 0 : int'(cur_rise) * TICKS_PER_MS - 1;
        high_lim  = (cur_fall == '0) ? 1 : int'(cur_fall) * TICKS_PER_MS;
        rise_wait = $urandom_range(0, 20);
        high_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 40);
        if (rise_wait > rise_lim) rise_wait = rise_lim;
        if (high_len > high_lim) high_len = high_lim;
        if (cur_rise == '0 && $urandom_range(0, 3) == 0)
        begin
            run_measure(1, 0, 1'b0);
        end
        else if (cur_fall == '0 && $urandom_range(0, 3) == 0)
        begin
            run_measure(rise_wait, 2, 1'b0);
        end
        else
        begin
            run_measure(rise_wait, high_len, 1'b1);
        end
        idle_noise($urandom_range(0, 3));
    endtask

    task random_phase(input int n_ticks, input bit with_hold);
        int first;
        first = tick_count;
        if (with_hold)
        begin
            hold_requests++;
        end
        while (tick_count - first < n_ticks) random_measure();
    endtask

    initial
    begin : stimulus
        in_bus.valid     <= 1'b0;
        in_bus.start_req <= 1'b0;
        in_bus.echo      <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_TRIGGER_TICKS;
        cfg_wdata        <= '0;
        cur_trig = RST_TRIGGER_TICKS;
        cur_rise = RST_RISE_TIMEOUT_MS;
        cur_fall = RST_FALL_TIMEOUT_MS;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a plain reading, echo noise while idle, then a rise timeout.
        hold_requests++;
        run_measure(5, 100, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        run_measure(TICKS_PER_MS, 0, 1'b0);

        // All zeros: a zero-length trigger acts as one tick, zero timeouts expire at once.
        configure(10'd0, 10'd0, 10'd0, 10'd0);
        run_measure(1, 0, 1'b0);
        run_measure(0, 2, 1'b0);
        run_measure(0, 1, 1'b1);

        // All ones: longest trigger, widest timeouts and shift; upper data bits are dropped.
        configure(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        run_measure(3, 40, 1'b1);

        // Millisecond carry in the rise wait, echo falling on the limit tick, fall timeout.
        configure(10'd1, 10'd2, 10'd1, 10'd0);
        run_measure(2 * TICKS_PER_MS, 0, 1'b0);
        run_measure(4, TICKS_PER_MS, 1'b1);
        run_measure(4, TICKS_PER_MS + 1, 1'b0);

        // A pulse of several milliseconds.
        configure(10'd3, 10'd1, 10'd3, 10'd2);
        run_measure(0, 2500, 1'b1);

        // Random part: zero fall timeout, then the widest timeouts, then a zero rise
        // timeout with no idling on either side.
        configure(10'($urandom_range(1, 15)), {4'($urandom), 6'($urandom_range(1, 63))},
                  {4'($urandom), 6'd0}, 10'($urandom_range(0, 15)));
        random_phase(RANDOM_TICKS / 3, 1'b1);
        configure(10'd10, 10'd63, 10'd63, 10'd0);
        random_phase(RANDOM_TICKS / 3, 1'b1);
        configure(10'($urandom_range(1, 8)), {4'($urandom), 6'd0},
                  {4'($urandom), 6'($urandom_range(1, 63))}, 10'($urandom_range(0, 15)));
        idle_on = 1'b0;
        random_phase(RANDOM_TICKS - 2 * (RANDOM_TICKS / 3), 1'b0);

        wait_for_results();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
